[rtl/core/assert_macros.svh]
// assertion helpers for the rtl, included by usv_back
// every user has aclk and aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define USV_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define USV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/usv_pkg.sv]
package usv_pkg;

    // byte counter width; reported length saturates at 16 bits
    localparam int LENGTH_BITS = 16;
    localparam int LEN_OUT_W   = 16;
    localparam int POINT_W     = 21;

    // queue between classifier and decoder
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [POINT_W-1:0] INVALID_POINT = 21'h110000;

    // byte classes found by the front end
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_CONT  = 3'd1,
        CLS_LEAD2 = 3'd2,
        CLS_LEAD3 = 3'd3,
        CLS_LEAD4 = 3'd4,
        CLS_BAD   = 3'd5
    } byte_class_t;

    // classified word carried through the queue
    typedef struct packed {
        byte_class_t cls;
        logic [6:0]  bits;
        logic        last;
    } byte_word_t;

    // write side of the queue
    typedef struct packed {
        logic       push;
        byte_word_t word;
    } queue_wr_t;

    // read side status of the queue
    typedef struct packed {
        logic       not_empty;
        byte_word_t word;
    } queue_rd_t;

endpackage

[rtl/core/usv_front.sv]
module usv_front
    import usv_pkg::*;
(
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_string,
    input  logic       queue_full,
    output queue_wr_t  queue_wr
);

    byte_class_t cls;

    // byte class from the lead bits
    always_comb begin
        unique case (s_data_byte) inside
            [8'h00:8'h7F]: cls = CLS_ASCII;
            [8'h80:8'hBF]: cls = CLS_CONT;
            [8'hC0:8'hDF]: cls = CLS_LEAD2;
            [8'hE0:8'hEF]: cls = CLS_LEAD3;
            [8'hF0:8'hF7]: cls = CLS_LEAD4;
            default:       cls = CLS_BAD;
        endcase
    end

    // accept a word whenever the queue has room
    assign s_ready             = !queue_full;
    assign queue_wr.push       = s_valid && !queue_full;
    assign queue_wr.word.cls   = cls;
    assign queue_wr.word.bits  = s_data_byte[6:0];
    assign queue_wr.word.last  = s_end_of_string;

endmodule

[rtl/core/usv_queue.sv]
module usv_queue
    import usv_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  queue_wr_t queue_wr,
    output logic      queue_full,
    input  logic      pop,
    output queue_rd_t queue_rd
);

    byte_word_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (queue_wr.push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (queue_wr.push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !queue_wr.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (queue_wr.push) begin
            mem_reg[wr_ptr_reg] <= queue_wr.word;
        end
    end

    assign queue_full         = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign queue_rd.not_empty = (count_reg != '0);
    assign queue_rd.word      = mem_reg[rd_ptr_reg];

endmodule

[rtl/core/usv_back.sv]
`include "assert_macros.svh"

module usv_back
    import usv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  queue_rd_t            queue_rd,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_point_ready,
    output logic [POINT_W-1:0]   m_code_point,
    output logic                 m_error_here,
    output logic                 m_string_done,
    output logic                 m_string_valid,
    output logic [LEN_OUT_W-1:0] m_valid_length
);

    // decoder state
    logic [POINT_W-1:0]     partial_point_reg, partial_point_next;
    logic [1:0]             bytes_pending_reg, bytes_pending_next;
    logic                   error_seen_reg, error_seen_next;
    logic [LENGTH_BITS-1:0] byte_count_reg, byte_count_next;
    logic [LENGTH_BITS-1:0] error_length_reg, error_length_next;

    // output register
    logic                 m_valid_reg;
    logic                 point_ready_reg, point_ready_next;
    logic [POINT_W-1:0]   code_point_reg, code_point_next;
    logic                 error_here_reg, error_here_next;
    logic                 string_done_reg;
    logic                 string_valid_reg, string_valid_next;
    logic [LEN_OUT_W-1:0] valid_length_reg, valid_length_next;

    byte_word_t             w;
    logic [LENGTH_BITS-1:0] count_inc;
    logic [1:0]             pend_dec;
    logic [POINT_W-1:0]     merged;
    logic                   err;
    logic                   ready;
    logic [POINT_W-1:0]     point;
    logic [LENGTH_BITS-1:0] len;
    logic [31:0]            len_wide;

    assign w   = queue_rd.word;
    assign pop = queue_rd.not_empty && (!m_valid_reg || m_ready);

    // saturating byte count
    assign count_inc = (byte_count_reg != '1) ? byte_count_reg + 1'b1 : byte_count_reg;
    assign pend_dec  = bytes_pending_reg - 1'b1;

    // continuation bits placed by the count still left after this byte
    always_comb begin
        case (pend_dec)
            2'd2:    merged = partial_point_reg | (POINT_W'(w.bits[5:0]) << 12);
            2'd1:    merged = partial_point_reg | (POINT_W'(w.bits[5:0]) << 6);
            default: merged = partial_point_reg | POINT_W'(w.bits[5:0]);
        endcase
    end

    // decode step for one word
    always_comb begin
        partial_point_next = partial_point_reg;
        bytes_pending_next = bytes_pending_reg;
        error_seen_next    = error_seen_reg;
        byte_count_next    = count_inc;
        error_length_next  = error_length_reg;
        err                = 1'b0;
        ready              = 1'b0;
        point              = '0;

        if (!error_seen_reg) begin
            if (bytes_pending_reg == 2'd0) begin
                unique case (w.cls)
                    CLS_ASCII: begin
                        ready = 1'b1;
                        point = POINT_W'(w.bits);
                    end
                    CLS_LEAD2: begin
                        partial_point_next = POINT_W'(w.bits[4:0]) << 6;
                        bytes_pending_next = 2'd1;
                    end
                    CLS_LEAD3: begin
                        partial_point_next = POINT_W'(w.bits[3:0]) << 12;
                        bytes_pending_next = 2'd2;
                    end
                    CLS_LEAD4: begin
                        partial_point_next = POINT_W'(w.bits[2:0]) << 18;
                        bytes_pending_next = 2'd3;
                    end
                    default: begin
                        err = 1'b1;
                    end
                endcase
            end else if (w.cls != CLS_CONT) begin
                err = 1'b1;
            end else begin
                bytes_pending_next = pend_dec;
                partial_point_next = merged;
                if (pend_dec == 2'd0) begin
                    if (merged == INVALID_POINT) begin
                        err = 1'b1;
                    end else begin
                        ready = 1'b1;
                        point = merged;
                    end
                end
            end

            // string ends inside a sequence
            if (!err && w.last && bytes_pending_next != 2'd0) begin
                err = 1'b1;
            end
            if (err) begin
                error_seen_next    = 1'b1;
                error_length_next  = count_inc;
                bytes_pending_next = 2'd0;
                partial_point_next = '0;
                ready              = 1'b0;
                point              = '0;
            end
        end

        point_ready_next = ready;
        code_point_next  = point;
        error_here_next  = err;

        // verdict and length at string end
        len               = error_seen_next ? error_length_next : byte_count_next;
        len_wide          = 32'(len);
        string_valid_next = 1'b0;
        valid_length_next = '0;
        if (w.last) begin
            string_valid_next  = !error_seen_next;
            valid_length_next  = (len_wide > 32'(16'hFFFF)) ? '1 : len_wide[LEN_OUT_W-1:0];
            partial_point_next = '0;
            bytes_pending_next = 2'd0;
            error_seen_next    = 1'b0;
            byte_count_next    = '0;
            error_length_next  = '0;
        end
    end

    // state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_point_reg <= '0;
            bytes_pending_reg <= 2'd0;
            error_seen_reg    <= 1'b0;
            byte_count_reg    <= '0;
            error_length_reg  <= '0;
        end else if (pop) begin
            partial_point_reg <= partial_point_next;
            bytes_pending_reg <= bytes_pending_next;
            error_seen_reg    <= error_seen_next;
            byte_count_reg    <= byte_count_next;
            error_length_reg  <= error_length_next;
        end
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            point_ready_reg  <= point_ready_next;
            code_point_reg   <= code_point_next;
            error_here_reg   <= error_here_next;
            string_done_reg  <= w.last;
            string_valid_reg <= string_valid_next;
            valid_length_reg <= valid_length_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_point_ready  = point_ready_reg;
    assign m_code_point   = code_point_reg;
    assign m_error_here   = error_here_reg;
    assign m_string_done  = string_done_reg;
    assign m_string_valid = string_valid_reg;
    assign m_valid_length = valid_length_reg;

    // checks
    `USV_ASSERT_ALWAYS(a_err_clears_pending, !error_seen_reg || bytes_pending_reg == 2'd0, "pending after error")
    `USV_ASSERT_ALWAYS(a_point_xor_err, !m_valid_reg || !(point_ready_reg && error_here_reg), "point and error together")
    `USV_ASSERT_ALWAYS(a_valid_at_end, !(m_valid_reg && string_valid_reg) || (string_done_reg && !error_here_reg), "bad verdict")
    `USV_ASSERT_NEXT(a_end_clears, pop && w.last, byte_count_reg == '0 && !error_seen_reg && bytes_pending_reg == 2'd0, "state kept past string end")

endmodule

[rtl/core/utf8_stream_validator.sv]
// channel | ports                                  | direction
// --------+----------------------------------------+----------
// input   | s_valid s_ready s_data_byte            | in
//         | s_end_of_string                        |
// result  | m_valid m_ready m_point_ready          | out
//         | m_code_point m_error_here m_string_done|
//         | m_string_valid m_valid_length          |
//
// one word in and one word out per clock sustained while m_ready stays high;
// an accepted word is written into the queue, then decoded into the output
// register, which raises m_valid
// the decoder update is a loop over the registered per-string state
// synchronous active-low reset empties the queue and clears decoder and output valid
// a two-word queue lets the input keep taking words while the output is stalled
// s_ready drops only when the queue is full
module utf8_stream_validator
    import usv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_end_of_string,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_point_ready,
    output logic [POINT_W-1:0]   m_code_point,
    output logic                 m_error_here,
    output logic                 m_string_done,
    output logic                 m_string_valid,
    output logic [LEN_OUT_W-1:0] m_valid_length
);

    queue_wr_t queue_wr;
    queue_rd_t queue_rd;
    logic      queue_full;
    logic      pop;

    // classify incoming bytes
    usv_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_string (s_end_of_string),
        .queue_full      (queue_full),
        .queue_wr        (queue_wr)
    );

    // decoupling queue
    usv_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .queue_wr   (queue_wr),
        .queue_full (queue_full),
        .pop        (pop),
        .queue_rd   (queue_rd)
    );

    // decode and report
    usv_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .queue_rd       (queue_rd),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_point_ready  (m_point_ready),
        .m_code_point   (m_code_point),
        .m_error_here   (m_error_here),
        .m_string_done  (m_string_done),
        .m_string_valid (m_string_valid),
        .m_valid_length (m_valid_length)
    );

endmodule

[tb/sv/utf8_stream_checker.sv]
module utf8_stream_checker
    import usv_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [7:0]           s_data_byte,
    input  logic                 s_end_of_string,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_point_ready,
    input  logic [POINT_W-1:0]   m_code_point,
    input  logic                 m_error_here,
    input  logic                 m_string_done,
    input  logic                 m_string_valid,
    input  logic [LEN_OUT_W-1:0] m_valid_length,
    output int unsigned          mismatches,
    output int unsigned          words_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    // one decoded result word
    typedef struct packed {
        logic                 point_ready;
        logic [POINT_W-1:0]   code_point;
        logic                 error_here;
        logic                 string_done;
        logic                 string_valid;
        logic [LEN_OUT_W-1:0] valid_length;
    } decoded_word_t;

    // per-string decoder state
    logic [POINT_W-1:0]     partial = '0;
    logic [1:0]             cont_left = '0;
    logic                   err_seen = 1'b0;
    logic [LENGTH_BITS-1:0] byte_cnt = '0;
    logic [LENGTH_BITS-1:0] err_len = '0;

    decoded_word_t decoded_q[$];

    initial begin
        mismatches = 0;
        words_owed = 0;
    end

    function automatic void clear_string();
        partial   = '0;
        cont_left = '0;
        err_seen  = 1'b0;
        byte_cnt  = '0;
        err_len   = '0;
    endfunction

    // decode one byte against the running string state
    function automatic decoded_word_t decode_byte(logic [7:0] b, logic last);
        decoded_word_t r;
        logic err;
        logic [LENGTH_BITS-1:0] len;
        r = '0;
        err = 1'b0;
        if (byte_cnt != '1)
            byte_cnt = byte_cnt + 1'b1;
        if (!err_seen) begin
            if (cont_left == 2'd0) begin
                // lead byte
                if (b < 8'h80) begin
                    r.point_ready = 1'b1;
                    r.code_point  = POINT_W'(b);
                end else if (b < 8'hC0) begin
                    err = 1'b1;
                end else if (b < 8'hE0) begin
                    partial   = POINT_W'(b[4:0]) << 6;
                    cont_left = 2'd1;
                end else if (b < 8'hF0) begin
                    partial   = POINT_W'(b[3:0]) << 12;
                    cont_left = 2'd2;
                end else if (b < 8'hF8) begin
                    partial   = POINT_W'(b[2:0]) << 18;
                    cont_left = 2'd3;
                end else begin
                    err = 1'b1;
                end
            end else if (b[7:6] != 2'b10) begin
                err = 1'b1;
            end else begin
                // continuation adds six bits
                cont_left = cont_left - 2'd1;
                partial   = partial | (POINT_W'(b[5:0]) << (6 * cont_left));
                if (cont_left == 2'd0) begin
                    if (partial == INVALID_POINT) begin
                        err = 1'b1;
                    end else begin
                        r.point_ready = 1'b1;
                        r.code_point  = partial;
                    end
                end
            end
            // string ends inside a sequence
            if (!err && last && cont_left != 2'd0)
                err = 1'b1;
            if (err) begin
                err_seen      = 1'b1;
                err_len       = byte_cnt;
                cont_left     = '0;
                partial       = '0;
                r.point_ready = 1'b0;
                r.code_point  = '0;
            end
        end
        r.error_here  = err;
        r.string_done = last;
        // verdict on the last byte
        if (last) begin
            len = err_seen ? err_len : byte_cnt;
            r.string_valid = !err_seen;
            if (64'(len) > ((64'd1 << LEN_OUT_W) - 64'd1))
                r.valid_length = '1;
            else
                r.valid_length = LEN_OUT_W'(len);
            clear_string();
        end
        return r;
    endfunction

    // predict on input handshakes, compare on output handshakes
    always @(posedge aclk) begin : watch
        decoded_word_t want;
        decoded_word_t seen;
        if (!aresetn) begin
            clear_string();
            decoded_q.delete();
        end else begin
            if (s_valid && s_ready)
                decoded_q.push_back(decode_byte(s_data_byte, s_end_of_string));
            if (m_valid && m_ready) begin
                seen = '{m_point_ready, m_code_point, m_error_here,
                         m_string_done, m_string_valid, m_valid_length};
                if (decoded_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected word ready=%0b point=%06h err=%0b done=%0b ok=%0b len=%0d",
                                 $realtime, seen.point_ready, seen.code_point, seen.error_here,
                                 seen.string_done, seen.string_valid, seen.valid_length);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    if (want.point_ready !== seen.point_ready ||
                        want.code_point !== seen.code_point ||
                        want.error_here !== seen.error_here ||
                        want.string_done !== seen.string_done ||
                        want.string_valid !== seen.string_valid ||
                        want.valid_length !== seen.valid_length) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch expected ready=%0b point=%06h err=%0b done=%0b ok=%0b len=%0d",
                                     $realtime, want.point_ready, want.code_point, want.error_here,
                                     want.string_done, want.string_valid, want.valid_length);
                            $display("%0t:          actual   ready=%0b point=%06h err=%0b done=%0b ok=%0b len=%0d",
                                     $realtime, seen.point_ready, seen.code_point, seen.error_here,
                                     seen.string_done, seen.string_valid, seen.valid_length);
                        end
                        mismatches++;
                    end
                end
            end
        end
        words_owed = decoded_q.size();
    end

endmodule

[tb/sv/utf8_stream_validator_test.sv]
module utf8_stream_validator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import usv_pkg::*;

    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 300;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_data_byte = '0;
    logic                 s_end_of_string = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_point_ready;
    logic [POINT_W-1:0]   m_code_point;
    logic                 m_error_here;
    logic                 m_string_done;
    logic                 m_string_valid;
    logic [LEN_OUT_W-1:0] m_valid_length;

    int unsigned mismatches;
    int unsigned words_owed;

    // no-idle mode and receiver hold-off request
    logic        calm = 1'b0;
    logic        hold_tog = 1'b0;
    logic        hold_seen = 1'b0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sent_cnt = 0;

    logic [7:0] str_q[$];

    always #5 aclk = ~aclk;

    utf8_stream_validator u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_point_ready   (m_point_ready),
        .m_code_point    (m_code_point),
        .m_error_here    (m_error_here),
        .m_string_done   (m_string_done),
        .m_string_valid  (m_string_valid),
        .m_valid_length  (m_valid_length)
    );

    utf8_stream_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_string (s_end_of_string),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_point_ready   (m_point_ready),
        .m_code_point    (m_code_point),
        .m_error_here    (m_error_here),
        .m_string_done   (m_string_done),
        .m_string_valid  (m_string_valid),
        .m_valid_length  (m_valid_length),
        .mismatches      (mismatches),
        .words_owed      (words_owed)
    );

    // receiver: random stalls, long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_tog != hold_seen) begin
            hold_seen <= hold_tog;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (calm) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= 26);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one word, with random idle cycles ahead of it
    task automatic send_word(input logic [7:0] b, input logic last);
        logic took;
        while (!calm && $urandom_range(99) < 26) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_data_byte     <= b;
        s_end_of_string <= last;
        took = 1'b0;
        while (!took) begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end
        sent_cnt++;
    endtask

    task automatic send_string();
        foreach (str_q[i])
            send_word(str_q[i], i == str_q.size() - 1);
        str_q.delete();
    endtask

    // stop offering until every result is back
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (words_owed != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic add_cont(input int unsigned n);
        repeat (n) str_q.push_back(8'($urandom_range(8'hBF, 8'h80)));
    endtask

    // one character: mostly well-formed, some noise
    task automatic add_char();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 28) begin
            str_q.push_back(8'($urandom_range(8'h7F)));
        end else if (pick < 46) begin
            str_q.push_back(8'($urandom_range(8'hDF, 8'hC0)));
            add_cont(1);
        end else if (pick < 64) begin
            str_q.push_back(8'($urandom_range(8'hEF, 8'hE0)));
            add_cont(2);
        end else if (pick < 80) begin
            str_q.push_back(8'($urandom_range(8'hF7, 8'hF0)));
            add_cont(3);
        end else if (pick < 84) begin
            // value just past the top of the code space
            str_q.push_back(8'hF4);
            str_q.push_back(8'h90);
            str_q.push_back(8'h80);
            str_q.push_back(8'h80);
        end else if (pick < 90) begin
            str_q.push_back(8'($urandom_range(8'hFF)));
        end else if (pick < 95) begin
            // sequence broken by a non-continuation byte
            str_q.push_back(8'($urandom_range(8'hF7, 8'hF0)));
            add_cont($urandom_range(2));
            if ($urandom_range(1) == 0)
                str_q.push_back(8'($urandom_range(8'h7F)));
            else
                str_q.push_back(8'($urandom_range(8'hFF, 8'hC0)));
        end else begin
            // stray continuation as a lead
            add_cont(1);
        end
    endtask

    task automatic random_string();
        int unsigned chars;
        chars = $urandom_range(10, 1);
        repeat (chars) add_char();
        // sometimes end on an open lead byte
        if ($urandom_range(9) == 0)
            str_q.push_back(8'($urandom_range(8'hF7, 8'hC0)));
        send_string();
    endtask

    // stimulus and verdict
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: both one-byte extremes, the lowest two-byte and the highest three- and four-byte values
        str_q = '{8'h00};
        send_string();
        str_q = '{8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_string();
        // out-of-range value, then ignored tail
        str_q = '{8'hF4, 8'h90, 8'h80, 8'h80, 8'h41};
        send_string();
        // bad lead bytes
        str_q = '{8'h80};
        send_string();
        str_q = '{8'h41, 8'hF8, 8'hC2};
        send_string();
        // bad continuation
        str_q = '{8'hC2, 8'h41};
        send_string();
        // sequence cut short by the string end
        str_q = '{8'hE1, 8'h80};
        send_string();
        wait_drained();

        // random with idling
        while (sent_cnt < 525)
            random_string();

        // stretch with no idling on either side
        calm <= 1'b1;
        while (sent_cnt < 850)
            random_string();
        calm <= 1'b0;

        // receiver holds off while the sender keeps offering
        hold_tog <= ~hold_tog;
        while (sent_cnt < 1100)
            random_string();
        wait_drained();

        while (sent_cnt < 1540)
            random_string();

        wait_drained();
        repeat (20) @(negedge aclk);
        if (mismatches == 0 && words_owed == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/usv_pkg.sv
rtl/core/usv_front.sv
rtl/core/usv_queue.sv
rtl/core/usv_back.sv
rtl/core/utf8_stream_validator.sv
tb/sv/utf8_stream_checker.sv
tb/sv/utf8_stream_validator_test.sv
